[rtl/resonance_peak_interpolator_defines.svh]
// ----------------------------------------------------------------------------
// Resonance peak interpolator assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef RESONANCE_PEAK_INTERPOLATOR_DEFINES_SVH
`define RESONANCE_PEAK_INTERPOLATOR_DEFINES_SVH

// same-cycle implication, off while in reset
`define RPI_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("rpi: same-cycle check failed");

// next-cycle implication, off while in reset
`define RPI_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("rpi: next-cycle check failed");

// condition that must hold in the cycle after reset is seen
`define RPI_ASSERT_RESET(lbl, clk_s, rst_s, cons) \
  lbl: assert property (@(posedge clk_s) (!rst_s) |=> (cons)) \
    else $error("rpi: post-reset check failed");

`endif

[rtl/rpi_pkg.sv]
// ----------------------------------------------------------------------------
// Resonance peak interpolator package
// Widths, register indexes, sequencer states and the CORDIC angle table.
// ----------------------------------------------------------------------------
`default_nettype none

package rpi_pkg;

  localparam int FREQ_W  = 36;
  localparam int MAG_W   = 32;
  localparam int ADM_W   = 32;
  localparam int PHASE_W = 17;
  localparam int IDX_W   = 9;
  localparam int CFG_W   = 36;
  localparam int FSUM_W  = 45;   // start plus up to 255 steps
  localparam int CX_W    = 59;   // CORDIC x/y with 24 fraction bits and gain
  localparam int Z_W     = 26;   // angle, degrees Q.16
  localparam int CORDIC_STEPS = 23;

  localparam logic [IDX_W-1:0] MAX_POINTS = 9'd256;

  localparam logic signed [Z_W-1:0] PHASE_HI = 26'sd46080;
  localparam logic signed [Z_W-1:0] PHASE_LO = -26'sd46080;
  localparam logic signed [Z_W-1:0] ANGLE_90 = 26'sd5898240;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_CENTER = 2'd0;
  localparam cfg_idx_t CFG_SPAN   = 2'd1;
  localparam cfg_idx_t CFG_COUNT  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STEP_DIV,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_ITER,
    ST_TRACK,
    ST_FINISH,
    ST_QDIV,
    ST_QMUL,
    ST_CENTER,
    ST_EMIT
  } rpi_state_t;

  // atan(2^-i) in degrees Q.16, rounded to nearest
  function automatic logic [21:0] rpi_atan(input logic [4:0] i);
    logic [21:0] a;
    case (i)
      5'd0:  a = 22'd2949120;
      5'd1:  a = 22'd1740967;
      5'd2:  a = 22'd919879;
      5'd3:  a = 22'd466945;
      5'd4:  a = 22'd234379;
      5'd5:  a = 22'd117304;
      5'd6:  a = 22'd58666;
      5'd7:  a = 22'd29335;
      5'd8:  a = 22'd14668;
      5'd9:  a = 22'd7334;
      5'd10: a = 22'd3667;
      5'd11: a = 22'd1833;
      5'd12: a = 22'd917;
      5'd13: a = 22'd458;
      5'd14: a = 22'd229;
      5'd15: a = 22'd115;
      5'd16: a = 22'd57;
      5'd17: a = 22'd29;
      5'd18: a = 22'd14;
      5'd19: a = 22'd7;
      5'd20: a = 22'd4;
      5'd21: a = 22'd2;
      5'd22: a = 22'd1;
      default: a = 22'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

[rtl/rpi_channels.sv]
// ----------------------------------------------------------------------------
// Resonance peak interpolator channels
// Valid/ready interfaces for the admittance words and the result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpi_in_if import rpi_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ADM_W-1:0] admittance_real;
  logic signed [ADM_W-1:0] admittance_imag;
  logic                    measure_failed;

  modport source (output valid, admittance_real, admittance_imag, measure_failed,
                  input ready);
  modport sink (input valid, admittance_real, admittance_imag, measure_failed,
                output ready);
  modport monitor (input valid, ready, admittance_real, admittance_imag, measure_failed);
endinterface

interface rpi_out_if import rpi_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [FREQ_W-1:0]         point_frequency;
  logic [MAG_W-1:0]          magnitude;
  logic signed [PHASE_W-1:0] phase_degrees;
  logic                      is_last;
  logic [FREQ_W-1:0]         refined_center;
  logic                      peak_interior;

  modport source (output valid, point_frequency, magnitude, phase_degrees, is_last,
                  refined_center, peak_interior, input ready);
  modport sink (input valid, point_frequency, magnitude, phase_degrees, is_last,
                refined_center, peak_interior, output ready);
  modport monitor (input valid, ready, point_frequency, magnitude, phase_degrees,
                   is_last, refined_center, peak_interior);
endinterface

`default_nettype wire

[rtl/resonance_peak_interpolator.sv]
// ----------------------------------------------------------------------------
// Resonance peak interpolator
// One admittance word in per sweep point, one result word out: frequency,
// magnitude, phase, and on the last point a parabolically refined center.
// in_chan carries admittance words, out_chan result words; both valid/ready.
// cfg_we/cfg_index/cfg_data set center, span and point count; the user is
// to write them only while idle, which the block itself does not enforce.
// One word is in work at a time; in_chan.ready is high only when idle.
// From accept to result an ordinary point passes the squarer and the shared
// isqrt/CORDIC loop (one radicand digit and one rotation per cycle), then
// peak tracking. The first point of a sweep first runs the serial step
// divider; on the last point an interior peak adds a serial divide, a
// shift-add multiply and a step that forms the center, and otherwise the
// configured center is given.
// The result sits in an output register; the next word is accepted while it
// waits. If the receiver stalls, a finished word waits in the sequencer
// until the register frees, and in_chan.ready stays low meanwhile.
// Reset clears configuration to center 0, span 0, count 1, the sweep index,
// peak tracking and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module resonance_peak_interpolator import rpi_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  rpi_in_if.sink                in_chan,
  rpi_out_if.source             out_chan,
  input  wire logic             cfg_we,
  input  wire cfg_idx_t         cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  rpi_state_t state_r, state_nxt;

  // configuration
  logic [FREQ_W-1:0] center_r, span_r;
  logic [IDX_W-1:0]  count_r, eff_cnt;

  // sweep and peak state
  logic [IDX_W-1:0]  pidx_r, best_idx_r;
  logic [FREQ_W-1:0] step_r, best_freq_r;
  logic [FSUM_W-1:0] fsum_r;
  logic [MAG_W-1:0]  prev_mag_r, best_mag_r, before_r, after_r;
  logic              captured_r;

  // word in work
  logic [ADM_W-1:0]  re_r, im_r;
  logic              fail_r, zero_r, last_r, dir_r;
  logic [5:0]        cnt_r;

  // step divider
  logic [FREQ_W-1:0] dvd_r;
  logic [IDX_W-1:0]  drem_r;
  logic [IDX_W:0]    drem_s, drem_n;
  logic              dge;

  // square and isqrt
  logic [63:0]       sq_r, sq_p;
  logic [ADM_W-1:0]  ar, ai, mul_a;
  logic [31:0]       root_r;
  logic [33:0]       srem_r;
  logic [35:0]       srem_s, strial;
  logic              sge;

  // CORDIC
  logic signed [CX_W-1:0] cx_r, cy_r, dx, dy;
  logic signed [Z_W-1:0]  cz_r, atan_s, zq, qz;
  logic signed [33:0]     re34, im34, xi, yi;
  logic signed [Z_W-1:0]  zi;

  // interpolation
  logic [34:0]       dsor_r, qrem_r;
  logic [35:0]       qrem_s, qrem_n;
  logic              qge;
  logic [23:0]       q_r;
  logic [59:0]       acc_r;
  logic [FREQ_W-1:0] off, cdown;
  logic [FREQ_W:0]   cup;
  logic [34:0]       d2;
  logic              interior;

  // tracking
  logic [MAG_W-1:0]  cur_mag;
  logic [FREQ_W-1:0] freq_sat, half;
  logic [PHASE_W-1:0] cur_ph;
  logic              accept, emit_go;

  // result hold and output register
  logic [FREQ_W-1:0]  res_freq_r, res_ref_r, o_freq_r, o_ref_r;
  logic [MAG_W-1:0]   res_mag_r, o_mag_r;
  logic [PHASE_W-1:0] res_ph_r, o_ph_r;
  logic               res_int_r, o_last_r, o_int_r, o_valid_r;

  assign accept  = in_chan.valid && (state_r == ST_IDLE);
  assign emit_go = (state_r == ST_EMIT) && (!o_valid_r || out_chan.ready);
  assign in_chan.ready = (state_r == ST_IDLE);

  // clamp the configured count into 1..MAX_POINTS
  always_comb begin
    if (count_r == '0) begin
      eff_cnt = 9'd1;
    end else if (count_r > MAX_POINTS) begin
      eff_cnt = MAX_POINTS;
    end else begin
      eff_cnt = count_r;
    end
  end

  // restoring divider step: span / count, one quotient bit a cycle
  assign drem_s = {drem_r, dvd_r[FREQ_W-1]};
  assign dge    = drem_s >= {1'b0, eff_cnt};
  assign drem_n = dge ? drem_s - {1'b0, eff_cnt} : drem_s;
  assign half   = {1'b0, span_r[FREQ_W-1:1]};

  // magnitudes and the shared squarer
  assign ar    = re_r[ADM_W-1] ? ~re_r + 32'd1 : re_r;
  assign ai    = im_r[ADM_W-1] ? ~im_r + 32'd1 : im_r;
  assign mul_a = (state_r == ST_SQ_RE) ? ar : ai;
  assign sq_p  = 64'(mul_a) * 64'(mul_a);

  // isqrt digit: two radicand bits per cycle
  assign srem_s = {srem_r, sq_r[63:62]};
  assign strial = {2'b00, root_r, 2'b01};
  assign sge    = srem_s >= strial;

  // CORDIC quadrant fold
  assign re34 = {{2{re_r[ADM_W-1]}}, re_r};
  assign im34 = {{2{im_r[ADM_W-1]}}, im_r};
  always_comb begin
    if (!re_r[ADM_W-1]) begin
      xi = re34;
      yi = im34;
      zi = '0;
    end else if (!im_r[ADM_W-1]) begin
      xi = im34;
      yi = -re34;
      zi = ANGLE_90;
    end else begin
      xi = -im34;
      yi = re34;
      zi = -ANGLE_90;
    end
  end

  // CORDIC rotation for the current step
  assign dx     = cy_r >>> cnt_r[4:0];
  assign dy     = cx_r >>> cnt_r[4:0];
  assign atan_s = signed'({4'b0000, rpi_atan(cnt_r[4:0])});

  // round angle to Q8.8 and clamp
  assign zq = cz_r + 26'sd128;
  assign qz = zq >>> 8;
  always_comb begin
    if (fail_r || zero_r) begin
      cur_ph = '0;
    end else if (qz > PHASE_HI) begin
      cur_ph = PHASE_HI[PHASE_W-1:0];
    end else if (qz < PHASE_LO) begin
      cur_ph = PHASE_LO[PHASE_W-1:0];
    end else begin
      cur_ph = qz[PHASE_W-1:0];
    end
  end

  assign cur_mag  = fail_r ? '0 : root_r;
  assign freq_sat = (fsum_r[FSUM_W-1:FREQ_W] != '0) ? '1 : fsum_r[FREQ_W-1:0];

  // interpolation divider and center
  assign d2 = ({3'b000, best_mag_r} << 2) - ({3'b000, before_r} << 1)
              - ({3'b000, after_r} << 1);
  assign interior = last_r && (best_idx_r != '0) && captured_r &&
                    (({1'b0, best_idx_r} + 10'd1) < {1'b0, eff_cnt});
  assign qrem_s = {qrem_r, 1'b0};
  assign qge    = qrem_s >= {1'b0, dsor_r};
  assign qrem_n = qge ? qrem_s - {1'b0, dsor_r} : qrem_s;
  assign off    = acc_r[59:24];
  assign cup    = {1'b0, best_freq_r} + {1'b0, off};
  assign cdown  = (best_freq_r > off) ? best_freq_r - off : '0;

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = (pidx_r == '0) ? ST_STEP_DIV : ST_SQ_RE;
      end
      ST_STEP_DIV: begin
        if (cnt_r == 6'd35) state_nxt = ST_SQ_RE;
      end
      ST_SQ_RE: state_nxt = ST_SQ_IM;
      ST_SQ_IM: state_nxt = ST_ITER;
      ST_ITER: begin
        if (cnt_r == 6'd31) state_nxt = ST_TRACK;
      end
      ST_TRACK:  state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = interior ? ST_QDIV : ST_EMIT;
      ST_QDIV: begin
        if (cnt_r == 6'd23) state_nxt = ST_QMUL;
      end
      ST_QMUL: begin
        if (cnt_r == 6'd23) state_nxt = ST_CENTER;
      end
      ST_CENTER: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (emit_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // configuration writes, sweep and peak state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r    <= '0;
      span_r      <= '0;
      count_r     <= 9'd1;
      pidx_r      <= '0;
      step_r      <= '0;
      fsum_r      <= '0;
      prev_mag_r  <= '0;
      best_mag_r  <= '0;
      best_idx_r  <= '0;
      before_r    <= '0;
      after_r     <= '0;
      captured_r  <= 1'b0;
      best_freq_r <= '0;
      o_valid_r   <= 1'b0;
      cnt_r       <= '0;
    end else begin
      cnt_r <= (state_nxt != state_r) ? '0 : cnt_r + 6'd1;

      if (cfg_we) begin
        case (cfg_index)
          CFG_CENTER: center_r <= cfg_data;
          CFG_SPAN:   span_r   <= cfg_data;
          CFG_COUNT:  count_r  <= cfg_data[IDX_W-1:0];
          default: ;
        endcase
      end

      // sweep start: place start frequency and clear the peak
      if (accept && pidx_r == '0) begin
        fsum_r     <= FSUM_W'((center_r > half) ? center_r - half : '0);
        prev_mag_r <= '0;
        best_mag_r <= '0;
        best_idx_r <= '0;
        before_r   <= '0;
        after_r    <= '0;
        captured_r <= 1'b0;
      end

      if (state_r == ST_STEP_DIV && cnt_r == 6'd35) begin
        step_r <= {dvd_r[FREQ_W-2:0], dge};
      end

      // track the first strict maximum and its neighbors
      if (state_r == ST_TRACK) begin
        if (cur_mag > best_mag_r) begin
          best_mag_r  <= cur_mag;
          best_idx_r  <= pidx_r;
          before_r    <= prev_mag_r;
          captured_r  <= 1'b0;
          best_freq_r <= freq_sat;
        end else if (!captured_r &&
                     ({1'b0, pidx_r} == ({1'b0, best_idx_r} + 10'd1))) begin
          after_r    <= cur_mag;
          captured_r <= 1'b1;
        end
        prev_mag_r <= cur_mag;
      end

      // advance the sweep as the word leaves
      if (emit_go) begin
        pidx_r <= last_r ? '0 : pidx_r + 9'd1;
        fsum_r <= fsum_r + FSUM_W'(step_r);
      end

      if (emit_go) begin
        o_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  // datapath: serial units and result hold
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        re_r   <= in_chan.admittance_real;
        im_r   <= in_chan.admittance_imag;
        fail_r <= in_chan.measure_failed;
        dvd_r  <= span_r;
        drem_r <= '0;
      end
      ST_STEP_DIV: begin
        dvd_r  <= {dvd_r[FREQ_W-2:0], dge};
        drem_r <= drem_n[IDX_W-1:0];
      end
      ST_SQ_RE: begin
        sq_r   <= sq_p;
        zero_r <= (re_r == '0) && (im_r == '0);
        cx_r   <= {xi[33], xi, 24'd0};
        cy_r   <= {yi[33], yi, 24'd0};
        cz_r   <= zi;
      end
      ST_SQ_IM: begin
        sq_r   <= sq_r + sq_p;
        root_r <= '0;
        srem_r <= '0;
      end
      ST_ITER: begin
        sq_r <= {sq_r[61:0], 2'b00};
        if (sge) begin
          srem_r <= 34'(srem_s - strial);
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          srem_r <= srem_s[33:0];
          root_r <= {root_r[30:0], 1'b0};
        end
        if (cnt_r < 6'(CORDIC_STEPS)) begin
          if (!cy_r[CX_W-1]) begin
            cx_r <= cx_r + dx;
            cy_r <= cy_r - dy;
            cz_r <= cz_r + atan_s;
          end else begin
            cx_r <= cx_r - dx;
            cy_r <= cy_r + dy;
            cz_r <= cz_r - atan_s;
          end
        end
      end
      ST_TRACK: begin
        res_freq_r <= freq_sat;
        res_mag_r  <= cur_mag;
        res_ph_r   <= cur_ph;
        res_ref_r  <= '0;
        res_int_r  <= 1'b0;
        last_r     <= ({1'b0, pidx_r} + 10'd1) >= {1'b0, eff_cnt};
      end
      ST_FINISH: begin
        dir_r  <= after_r > before_r;
        dsor_r <= d2;
        qrem_r <= 35'((after_r > before_r) ? after_r - before_r : before_r - after_r);
        q_r    <= '0;
        acc_r  <= '0;
        if (last_r && !interior) res_ref_r <= center_r;
      end
      ST_QDIV: begin
        qrem_r <= qrem_n[34:0];
        q_r    <= {q_r[22:0], qge};
      end
      ST_QMUL: begin
        acc_r <= {acc_r[58:0], 1'b0} + (q_r[23] ? 60'(step_r) : 60'd0);
        q_r   <= {q_r[22:0], 1'b0};
      end
      ST_CENTER: begin
        res_ref_r <= dir_r ? (cup[FREQ_W] ? '1 : cup[FREQ_W-1:0]) : cdown;
        res_int_r <= 1'b1;
      end
      default: ;
    endcase

    // load the output register
    if (emit_go) begin
      o_freq_r <= res_freq_r;
      o_mag_r  <= res_mag_r;
      o_ph_r   <= res_ph_r;
      o_last_r <= last_r;
      o_ref_r  <= res_ref_r;
      o_int_r  <= res_int_r;
    end
  end

  assign out_chan.valid           = o_valid_r;
  assign out_chan.point_frequency = o_freq_r;
  assign out_chan.magnitude       = o_mag_r;
  assign out_chan.phase_degrees   = o_ph_r;
  assign out_chan.is_last         = o_last_r;
  assign out_chan.refined_center  = o_ref_r;
  assign out_chan.peak_interior   = o_int_r;

endmodule

`default_nettype wire

[rtl/rpi_checker.sv]
// ----------------------------------------------------------------------------
// Resonance peak interpolator port checker
// Watches the channels of the top level and flags protocol or result slips.
// ----------------------------------------------------------------------------
`default_nettype none
`include "resonance_peak_interpolator_defines.svh"

module rpi_checker import rpi_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [FREQ_W-1:0] out_point_frequency,
  input wire logic [MAG_W-1:0]  out_magnitude,
  input wire logic              out_is_last,
  input wire logic [FREQ_W-1:0] out_refined_center,
  input wire logic              out_peak_interior
);

  // stalled result word holds
  `RPI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_magnitude) && $stable(out_point_frequency))

  // one word in work at a time: ready drops right after an accept
  `RPI_ASSERT_NEXT(a_one_in_work, clk, rst_n, in_valid && in_ready, !in_ready)

  // refinement fields stay clear except on the last point
  `RPI_ASSERT_IMP(a_refine_last, clk, rst_n, out_valid && !out_is_last, !out_peak_interior && (out_refined_center == '0))

  // no result word right after reset
  `RPI_ASSERT_RESET(a_reset_quiet, clk, rst_n, !out_valid)

endmodule

bind resonance_peak_interpolator rpi_checker u_rpi_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_chan.valid),
  .in_ready            (in_chan.ready),
  .out_valid           (out_chan.valid),
  .out_ready           (out_chan.ready),
  .out_point_frequency (out_chan.point_frequency),
  .out_magnitude       (out_chan.magnitude),
  .out_is_last         (out_chan.is_last),
  .out_refined_center  (out_chan.refined_center),
  .out_peak_interior   (out_chan.peak_interior)
);

`default_nettype wire
